// ----- sv/rwcs_pkg.sv -----
// Package for the RIFF/WAVE chunk scanner: tag words, smpl offsets, status codes.
// No dependencies; used by riff_wave_chunk_scanner and its port checker.
package rwcs_pkg;

    // Tags packed little-endian, first character in bits 7:0
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_SMPL = 32'h6c70_6d73;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Byte offsets inside the smpl body
    localparam logic [5:0] LOOP_COUNT_AT = 6'd28;
    localparam logic [5:0] LOOP_START_AT = 6'd44;
    localparam logic [5:0] LOOP_END_AT   = 6'd48;
    localparam logic [6:0] SMPL_SPAN     = 7'd52;

    typedef enum logic [1:0] {
        ST_NOT_WAVE = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_FOUND    = 2'd2
    } status_t;

endpackage

// ----- sv/riff_wave_chunk_scanner.sv -----
// RIFF/WAVE chunk scanner: byte-wide header walker with target and smpl capture.
// Depends on rwcs_pkg (tags, smpl offsets, status codes).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | sink      | in_valid/in_stall  | file_byte, last_byte
//  out     | source    | out_valid/out_stall| status, chunk_offset, chunk_len,
//          |           |                    | loop_found, loop_first, loop_last
//  cfg     | sink      | cfg_write          | cfg_data (target tag)
//
// One byte per cycle unless a last byte waits on a stalled result. A byte is held in the
// input register, then updates the scan state; a last byte also loads the result register.
// Reset restores the target tag to 'data' and clears the scan state.
// A stalled result holds off only a last byte; ordinary bytes keep flowing past it.
module riff_wave_chunk_scanner
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  file_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] chunk_offset,
    output logic [31:0] chunk_len,
    output logic        loop_found,
    output logic [31:0] loop_first,
    output logic [31:0] loop_last
);

    typedef enum logic [2:0] {
        PH_RIFF  = 3'd0,
        PH_RSIZE = 3'd1,
        PH_WAVE  = 3'd2,
        PH_TAG   = 3'd3,
        PH_LEN   = 3'd4,
        PH_SKIP  = 3'd5,
        PH_IDLE  = 3'd6
    } phase_t;

    logic [31:0] target_tag_reg;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] word_reg, word_next;
    logic [1:0]  wcnt_reg, wcnt_next;
    logic [31:0] tag_hold_reg, tag_hold_next;
    logic [31:0] skip_reg, skip_next;
    logic        tgt_seen_reg, tgt_seen_next;
    logic [31:0] tgt_off_reg, tgt_off_next;
    logic [31:0] tgt_size_reg, tgt_size_next;
    logic [5:0]  smpl_idx_reg, smpl_idx_next;
    logic        smpl_act_reg, smpl_act_next;
    logic        lcnt_nz_reg, lcnt_nz_next;
    logic [31:0] lstart_reg, lstart_next;
    logic [31:0] lend_reg, lend_next;
    logic        loop_seen_reg, loop_seen_next;
    logic        bad_reg, bad_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg;
    logic [31:0] chunk_offset_reg;
    logic [31:0] chunk_len_reg;
    logic        loop_found_reg;
    logic [31:0] loop_first_reg;
    logic [31:0] loop_last_reg;

    logic        accept;
    logic        proc;
    logic        emit;
    logic        word_done;
    logic [6:0]  smpl_sum;
    rwcs_pkg::status_t st_calc;
    logic [31:0] res_off;
    logic [31:0] res_len;
    logic        res_loop;
    logic [31:0] res_first;
    logic [31:0] res_last;

    assign accept = in_valid && !in_stall;
    // a last byte waits while the previous result is still stalled
    assign proc     = s1_valid_reg && !(s1_last_reg && out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !proc;
    assign emit     = proc && s1_last_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        word_next      = word_reg;
        wcnt_next      = wcnt_reg;
        tag_hold_next  = tag_hold_reg;
        skip_next      = skip_reg;
        tgt_seen_next  = tgt_seen_reg;
        tgt_off_next   = tgt_off_reg;
        tgt_size_next  = tgt_size_reg;
        smpl_idx_next  = smpl_idx_reg;
        smpl_act_next  = smpl_act_reg;
        lcnt_nz_next   = lcnt_nz_reg;
        lstart_next    = lstart_reg;
        lend_next      = lend_reg;
        loop_seen_next = loop_seen_reg;
        bad_next       = bad_reg;
        word_done      = 1'b0;
        smpl_sum       = {1'b0, smpl_idx_reg} + 7'd1;

        // smpl body capture runs alongside the chunk walk
        if (smpl_act_reg)
        begin
            if (smpl_idx_reg >= rwcs_pkg::LOOP_COUNT_AT
                && smpl_idx_reg < rwcs_pkg::LOOP_COUNT_AT + 6'd4 && s1_byte_reg != 8'd0)
            begin
                lcnt_nz_next = 1'b1;
            end
            if (smpl_idx_reg >= rwcs_pkg::LOOP_START_AT
                && smpl_idx_reg < rwcs_pkg::LOOP_START_AT + 6'd4)
            begin
                lstart_next = {s1_byte_reg, lstart_reg[31:8]};
            end
            if (smpl_idx_reg >= rwcs_pkg::LOOP_END_AT
                && smpl_idx_reg < rwcs_pkg::LOOP_END_AT + 6'd4)
            begin
                lend_next = {s1_byte_reg, lend_reg[31:8]};
            end
            if (smpl_sum >= rwcs_pkg::SMPL_SPAN)
            begin
                smpl_act_next = 1'b0;
                if (lcnt_nz_next)
                begin
                    loop_seen_next = 1'b1;
                end
            end
            smpl_idx_next = smpl_sum[5:0];
        end

        if (phase_reg <= PH_LEN)
        begin
            word_next = {s1_byte_reg, word_reg[31:8]};
            wcnt_next = wcnt_reg + 2'd1;
            word_done = (wcnt_reg == 2'd3);
        end

        unique case (phase_reg)
            PH_RIFF:
            begin
                if (word_done)
                begin
                    if (word_next != rwcs_pkg::TAG_RIFF)
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_RSIZE;
                    end
                end
            end
            PH_RSIZE:
            begin
                if (word_done)
                begin
                    phase_next = PH_WAVE;
                end
            end
            PH_WAVE:
            begin
                if (word_done)
                begin
                    if (word_next != rwcs_pkg::TAG_WAVE)
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
            end
            PH_TAG:
            begin
                if (word_done)
                begin
                    tag_hold_next = word_next;
                    phase_next    = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (word_done)
                begin
                    if (tag_hold_reg == target_tag_reg && !tgt_seen_reg)
                    begin
                        tgt_seen_next = 1'b1;
                        tgt_off_next  = pos_reg + 32'd1;
                        tgt_size_next = word_next;
                    end
                    // arm only once: the index stays nonzero after the first smpl body
                    if (tag_hold_reg == rwcs_pkg::TAG_SMPL && !smpl_act_next
                        && smpl_idx_next == 6'd0)
                    begin
                        smpl_act_next = 1'b1;
                        smpl_idx_next = 6'd0;
                    end
                    skip_next  = word_next;
                    phase_next = (word_next != 32'd0) ? PH_SKIP : PH_TAG;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0)
                begin
                    phase_next = PH_TAG;
                end
            end
            default:
            begin
            end
        endcase

        pos_next = pos_reg + 32'd1;

        if (bad_next || phase_next <= PH_WAVE)
        begin
            st_calc = rwcs_pkg::ST_NOT_WAVE;
        end
        else if (tgt_seen_next)
        begin
            st_calc = rwcs_pkg::ST_FOUND;
        end
        else
        begin
            st_calc = rwcs_pkg::ST_ABSENT;
        end

        // take the result from the scan state before it is cleared
        res_off   = (st_calc == rwcs_pkg::ST_FOUND) ? tgt_off_next : 32'd0;
        res_len   = (st_calc == rwcs_pkg::ST_FOUND) ? tgt_size_next : 32'd0;
        res_loop  = loop_seen_next;
        res_first = loop_seen_next ? lstart_next : 32'd0;
        res_last  = loop_seen_next ? lend_next : 32'd0;

        // next file starts from a clean scan
        if (s1_last_reg)
        begin
            phase_next     = PH_RIFF;
            pos_next       = 32'd0;
            word_next      = 32'd0;
            wcnt_next      = 2'd0;
            tag_hold_next  = 32'd0;
            skip_next      = 32'd0;
            tgt_seen_next  = 1'b0;
            tgt_off_next   = 32'd0;
            tgt_size_next  = 32'd0;
            smpl_idx_next  = 6'd0;
            smpl_act_next  = 1'b0;
            lcnt_nz_next   = 1'b0;
            lstart_next    = 32'd0;
            lend_next      = 32'd0;
            loop_seen_next = 1'b0;
            bad_next       = 1'b0;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (proc)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_tag_reg <= rwcs_pkg::TAG_DATA;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_RIFF;
            pos_reg        <= 32'd0;
            word_reg       <= 32'd0;
            wcnt_reg       <= 2'd0;
            tag_hold_reg   <= 32'd0;
            skip_reg       <= 32'd0;
            tgt_seen_reg   <= 1'b0;
            tgt_off_reg    <= 32'd0;
            tgt_size_reg   <= 32'd0;
            smpl_idx_reg   <= 6'd0;
            smpl_act_reg   <= 1'b0;
            lcnt_nz_reg    <= 1'b0;
            lstart_reg     <= 32'd0;
            lend_reg       <= 32'd0;
            loop_seen_reg  <= 1'b0;
            bad_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                target_tag_reg <= cfg_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                word_reg      <= word_next;
                wcnt_reg      <= wcnt_next;
                tag_hold_reg  <= tag_hold_next;
                skip_reg      <= skip_next;
                tgt_seen_reg  <= tgt_seen_next;
                tgt_off_reg   <= tgt_off_next;
                tgt_size_reg  <= tgt_size_next;
                smpl_idx_reg  <= smpl_idx_next;
                smpl_act_reg  <= smpl_act_next;
                lcnt_nz_reg   <= lcnt_nz_next;
                lstart_reg    <= lstart_next;
                lend_reg      <= lend_next;
                loop_seen_reg <= loop_seen_next;
                bad_reg       <= bad_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= file_byte;
            s1_last_reg <= last_byte;
        end
        if (emit)
        begin
            status_reg       <= st_calc;
            chunk_offset_reg <= res_off;
            chunk_len_reg    <= res_len;
            loop_found_reg   <= res_loop;
            loop_first_reg   <= res_first;
            loop_last_reg    <= res_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chunk_offset = chunk_offset_reg;
    assign chunk_len    = chunk_len_reg;
    assign loop_found   = loop_found_reg;
    assign loop_first   = loop_first_reg;
    assign loop_last    = loop_last_reg;

endmodule

// ----- sv/rwcs_port_check.sv -----
// Port-level checker for riff_wave_chunk_scanner, with its bind statement.
// Depends on rwcs_pkg (status codes).
module rwcs_port_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] chunk_offset,
    input logic [31:0] chunk_len,
    input logic        loop_found,
    input logic [31:0] loop_first,
    input logic [31:0] loop_last
);

    // offset and size only carry data when the target was found
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != rwcs_pkg::ST_FOUND |-> chunk_offset == 32'd0
            && chunk_len == 32'd0)
        else $error("target fields nonzero without a found target");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !loop_found |-> loop_first == 32'd0 && loop_last == 32'd0)
        else $error("loop points nonzero without a loop");

    // a smpl chunk is only reachable past a good RIFF/WAVE header
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == rwcs_pkg::ST_NOT_WAVE |-> !loop_found)
        else $error("loop reported for a file that is not RIFF/WAVE");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(chunk_offset)
            && $stable(loop_first))
        else $error("stalled result changed");

endmodule

bind riff_wave_chunk_scanner rwcs_port_check u_rwcs_port_check
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .chunk_offset (chunk_offset),
    .chunk_len    (chunk_len),
    .loop_found   (loop_found),
    .loop_first   (loop_first),
    .loop_last    (loop_last)
);
